[rtl/core/repair_source_least_used_select_unit_macros.svh]
// Assertion helpers for the repair source selector.
// Each macro builds a clocked assertion on i_clk that is disabled in reset.
`ifndef REPAIR_SOURCE_LEAST_USED_SELECT_UNIT_MACROS_SVH
`define REPAIR_SOURCE_LEAST_USED_SELECT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RSLUS_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("rslus assertion failed");
`define RSLUS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rslus implication failed");
`else
`define RSLUS_ASSERT(lbl, expr)
`define RSLUS_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

[rtl/core/rslus_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rslus_pkg
// Types and constants shared by the repair source selector.
// ---------------------------------------------------------------------------
package rslus_pkg;

    localparam int CHUNKS      = 16;
    localparam int CIDX_W      = $clog2(CHUNKS);
    localparam int CCNT_W      = $clog2(CHUNKS + 1);
    localparam int NODES       = 64;
    localparam int NODE_AW     = $clog2(NODES);
    localparam int LIST_DEPTH  = 4096;
    localparam int LL_W        = $clog2(LIST_DEPTH + 1);
    localparam int POS_W       = 12;
    localparam int PC_W        = 16;
    localparam int MAX_RESULTS = 16;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    localparam logic [PC_W-1:0] PC_MAX = {PC_W{1'b1}};
    localparam logic [LL_W-1:0] LL_FULL = LL_W'(LIST_DEPTH);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LIST_DEPTH - 1);

    typedef enum logic [1:0] {
        CFG_DATA_CHUNKS     = 2'd0,
        CFG_FAIL_FIRST_NODE = 2'd1,
        CFG_FAIL_NODE_COUNT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic        command;
        logic [5:0]  node_id;
        logic [15:0] stripe_record;
        logic        last_chunk;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  slot;
        logic [3:0]  chunk_index;
        logic [5:0]  picked_node;
        logic        is_failed;
        logic [11:0] list_position;
        logic [15:0] record_out;
        logic        list_full;
        logic        last_pick;
    } t_out_item;

    typedef struct packed {
        logic               clear;
        logic               rd_en;
        logic [NODE_AW-1:0] rd_addr;
        logic               pc_we;
        logic               ll_we;
        logic [NODE_AW-1:0] wr_addr;
        logic [PC_W-1:0]    pc_wdata;
        logic [LL_W-1:0]    ll_wdata;
    } t_store_req;

    typedef struct packed {
        logic [PC_W-1:0] pc;
        logic [LL_W-1:0] ll;
    } t_store_rsp;

endpackage

[rtl/core/rslus_node_store.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rslus_node_store
// Per-node pick counts and task-list lengths in two synchronous memories.
// ---------------------------------------------------------------------------
module rslus_node_store
    import rslus_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_store_req i_req,
    output t_store_rsp o_rsp
);

    logic [PC_W-1:0] r_pc_mem [NODES];
    logic [LL_W-1:0] r_ll_mem [NODES];
    logic [NODES-1:0] r_pc_vld;
    logic [NODES-1:0] r_ll_vld;
    logic [PC_W-1:0] r_pc_q;
    logic [LL_W-1:0] r_ll_q;
    logic r_pc_qv;
    logic r_ll_qv;

    // An entry not written since the last clear reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clear) begin
            r_pc_vld <= '0;
            r_ll_vld <= '0;
        end else begin
            if (i_req.pc_we) r_pc_vld[i_req.wr_addr] <= 1'b1;
            if (i_req.ll_we) r_ll_vld[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.pc_we) r_pc_mem[i_req.wr_addr] <= i_req.pc_wdata;
        if (i_req.ll_we) r_ll_mem[i_req.wr_addr] <= i_req.ll_wdata;
        if (i_req.rd_en) begin
            r_pc_q  <= r_pc_mem[i_req.rd_addr];
            r_ll_q  <= r_ll_mem[i_req.rd_addr];
            r_pc_qv <= r_pc_vld[i_req.rd_addr];
            r_ll_qv <= r_ll_vld[i_req.rd_addr];
        end
    end

    assign o_rsp.pc = r_pc_qv ? r_pc_q : '0;
    assign o_rsp.ll = r_ll_qv ? r_ll_q : '0;

endmodule

[rtl/core/repair_source_least_used_select_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// repair_source_least_used_select_unit
// Picks repair source chunks per stripe, balancing by per-node pick counts.
// ---------------------------------------------------------------------------
// Input channel (i_in_*): one transfer per chunk location or clear command.
// A clear command clears all per-node counts at once through valid bits.
// On the last chunk the unit stops accepting input and closes the stripe.
// It then reads each chunk's pick count from the node store. Each place of
// the sorted order then takes a select step, a scan over the buffered
// keys and a check step, plus an update step if it is picked.
// The failed-chunk scan follows, with a check and an update step per failed result.
// A final flush state ends the stripe.
// Output channel (o_out_*): results go out through an output register and
// one hold register; the final result of a stripe carries last_pick and
// leaves once the stripe is done. A stalled receiver pauses the sequencer
// before its next memory read; nothing is dropped.
// Reset returns the configuration to K=6, first failed node 0, F=1, and
// clears the chunk buffer and all per-node counts.
// ---------------------------------------------------------------------------
`include "repair_source_least_used_select_unit_macros.svh"

module repair_source_least_used_select_unit
    import rslus_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [5:0] i_cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LOAD  = 8'b0000_0010,
        S_SEL   = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_CHK   = 8'b0001_0000,
        S_UPD   = 8'b0010_0000,
        S_FSCAN = 8'b0100_0000,
        S_FLUSH = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [3:0] r_k;
    logic [5:0] r_ffn;
    logic [3:0] r_f;

    logic [5:0]      r_nodes [CHUNKS];
    logic [PC_W-1:0] r_keys  [CHUNKS];
    logic [CHUNKS-1:0] r_taken;
    logic [CCNT_W-1:0] r_cnt;
    logic [15:0]       r_rec;

    logic [CCNT_W-1:0] r_idx;
    logic              r_ld_vld;
    logic [CIDX_W-1:0] r_ld_idx;
    logic [CCNT_W-1:0] r_i;
    logic [CCNT_W-1:0] r_j;
    logic [3:0]        r_picks;
    logic [NRES_W-1:0] r_nres;
    logic [NRES_W-1:0] r_fslot;
    logic              r_have;
    logic [CIDX_W-1:0] r_best;
    logic [PC_W-1:0]   r_bkey;
    logic [CIDX_W-1:0] r_ci;
    logic [NODE_AW-1:0] r_addr;
    logic              r_phase;

    t_out_item r_hold, r_out;
    logic      r_hold_vld, r_out_vld;

    t_store_req store_req;
    t_store_rsp store_rsp;

    logic              in_xfer, out_xfer, out_room, out_load;
    logic [4:0]        win_raw;
    logic [CCNT_W-1:0] win;
    logic              sel_go;
    logic              cand;
    logic [CIDX_W-1:0] scan_ci;
    logic [5:0]        ci_node, fs_node;
    logic              ci_failed, fs_failed;
    logic              chk_emit;
    logic              ll_full;
    t_out_item         new_res;
    t_out_item         hold_last;

    function automatic logic node_fail(input logic [5:0] node, input logic [5:0] first,
                                       input logic [3:0] count);
        logic [5:0] diff;
        diff = node - first;
        return (node >= first) && (diff < {2'b00, count});
    endfunction

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = r_out_vld && i_out_ready;
    assign out_room = !r_out_vld || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // The hold register moves into the output register on an update, or
    // at the end of the stripe once the output register has room.
    assign out_load = r_hold_vld &&
                      ((r_state == S_UPD) || ((r_state == S_FLUSH) && out_room));

    assign win_raw = {1'b0, r_k} + {1'b0, r_f};
    assign win     = (CCNT_W'(win_raw) > r_cnt) ? r_cnt : CCNT_W'(win_raw);
    assign sel_go  = (r_i < win) && (r_picks < r_k);

    assign cand    = !r_taken[r_j[CIDX_W-1:0]] &&
                     (!r_have || (r_keys[r_j[CIDX_W-1:0]] < r_bkey));
    assign scan_ci = cand ? r_j[CIDX_W-1:0] : r_best;

    assign ci_node   = r_nodes[r_ci];
    assign ci_failed = node_fail(ci_node, r_ffn, r_f);
    assign fs_node   = r_nodes[r_j[CIDX_W-1:0]];
    assign fs_failed = node_fail(fs_node, r_ffn, r_f);

    // The output register must be free by the update cycle if the hold
    // register is to move into it then.
    assign chk_emit = (r_phase || !ci_failed) && (!r_hold_vld || out_room);

    assign ll_full = (store_rsp.ll == LL_FULL);

    always_comb begin
        new_res.slot          = r_phase ? r_fslot[3:0] : (r_f + r_picks);
        new_res.chunk_index   = r_ci;
        new_res.picked_node   = ci_node;
        new_res.is_failed     = r_phase;
        new_res.list_position = ll_full ? POS_LAST : store_rsp.ll[POS_W-1:0];
        new_res.record_out    = r_rec;
        new_res.list_full     = ll_full;
        new_res.last_pick     = 1'b0;
    end

    always_comb begin
        hold_last           = r_hold;
        hold_last.last_pick = 1'b1;
    end

    always_comb begin
        store_req          = '0;
        store_req.clear    = in_xfer && i_in_data.command;
        store_req.wr_addr  = r_addr;
        store_req.pc_wdata = store_rsp.pc + PC_W'(1);
        store_req.ll_wdata = store_rsp.ll + LL_W'(1);
        unique case (r_state)
            S_LOAD: begin
                store_req.rd_en   = (r_idx < r_cnt);
                store_req.rd_addr = r_nodes[r_idx[CIDX_W-1:0]][NODE_AW-1:0];
            end
            S_CHK: begin
                store_req.rd_en   = chk_emit;
                store_req.rd_addr = ci_node[NODE_AW-1:0];
            end
            S_UPD: begin
                store_req.pc_we = !r_phase && (store_rsp.pc != PC_MAX);
                store_req.ll_we = !ll_full;
            end
            default: begin
            end
        endcase
    end

    rslus_node_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (store_req),
        .o_rsp   (store_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_xfer && !i_in_data.command && i_in_data.last_chunk) n_state = S_LOAD;
            S_LOAD:  if (r_idx == r_cnt && !r_ld_vld) n_state = S_SEL;
            S_SEL:   n_state = sel_go ? S_SCAN : S_FSCAN;
            S_SCAN:  if (r_j == r_cnt - CCNT_W'(1)) n_state = S_CHK;
            S_CHK: begin
                if (!r_phase && ci_failed) n_state = S_SEL;
                else if (chk_emit)        n_state = S_UPD;
            end
            S_UPD:   n_state = r_phase ? S_FSCAN : S_SEL;
            S_FSCAN: begin
                if (r_j == r_cnt || r_nres == NRES_W'(MAX_RESULTS)) n_state = S_FLUSH;
                else if (fs_failed) n_state = S_CHK;
            end
            S_FLUSH: if (!r_hold_vld || out_room) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_k        <= 4'd6;
            r_ffn      <= 6'd0;
            r_f        <= 4'd1;
            r_cnt      <= '0;
            r_nres     <= '0;
            r_ld_vld   <= 1'b0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_DATA_CHUNKS:     r_k   <= i_cfg_data[3:0];
                    CFG_FAIL_FIRST_NODE: r_ffn <= i_cfg_data;
                    CFG_FAIL_NODE_COUNT: r_f   <= i_cfg_data[3:0];
                    default: ;
                endcase
            end

            if (out_load)      r_out_vld <= 1'b1;
            else if (out_xfer) r_out_vld <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_in_data.command) begin
                            r_cnt <= '0;
                        end else begin
                            if (r_cnt < CCNT_W'(CHUNKS)) begin
                                r_nodes[r_cnt[CIDX_W-1:0]] <= i_in_data.node_id;
                                r_cnt <= r_cnt + CCNT_W'(1);
                            end
                            r_rec    <= i_in_data.stripe_record;
                            r_idx    <= '0;
                            r_ld_vld <= 1'b0;
                        end
                    end
                end
                S_LOAD: begin
                    if (r_ld_vld) r_keys[r_ld_idx] <= store_rsp.pc;
                    r_ld_vld <= store_req.rd_en;
                    r_ld_idx <= r_idx[CIDX_W-1:0];
                    if (store_req.rd_en) r_idx <= r_idx + CCNT_W'(1);
                    r_taken <= '0;
                    r_i     <= '0;
                    r_picks <= '0;
                    r_nres  <= '0;
                    r_fslot <= '0;
                    r_phase <= 1'b0;
                end
                S_SEL: begin
                    r_j    <= '0;
                    r_have <= 1'b0;
                    if (!sel_go) r_phase <= 1'b1;
                end
                S_SCAN: begin
                    r_best <= scan_ci;
                    if (cand) begin
                        r_have <= 1'b1;
                        r_bkey <= r_keys[r_j[CIDX_W-1:0]];
                    end
                    r_j <= r_j + CCNT_W'(1);
                    if (r_j == r_cnt - CCNT_W'(1)) begin
                        r_ci <= scan_ci;
                        r_taken[scan_ci] <= 1'b1;
                        r_i <= r_i + CCNT_W'(1);
                    end
                end
                S_CHK: begin
                    r_addr <= ci_node[NODE_AW-1:0];
                end
                S_UPD: begin
                    if (r_hold_vld) r_out <= r_hold;
                    r_hold     <= new_res;
                    r_hold_vld <= 1'b1;
                    r_nres     <= r_nres + NRES_W'(1);
                    if (r_phase) begin
                        r_fslot <= r_fslot + NRES_W'(1);
                        r_j     <= r_j + CCNT_W'(1);
                    end else begin
                        r_picks <= r_picks + 4'd1;
                    end
                end
                S_FSCAN: begin
                    if (!(r_j == r_cnt || r_nres == NRES_W'(MAX_RESULTS))) begin
                        if (fs_failed) r_ci <= r_j[CIDX_W-1:0];
                        else           r_j  <= r_j + CCNT_W'(1);
                    end
                end
                S_FLUSH: begin
                    if (!r_hold_vld || out_room) begin
                        if (r_hold_vld) r_out <= hold_last;
                        r_hold_vld <= 1'b0;
                        r_cnt      <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    `RSLUS_ASSERT_IMP(a_upd_out_free, (r_state == S_UPD) && r_hold_vld, !r_out_vld)
    `RSLUS_ASSERT(a_nres_bound, r_nres <= NRES_W'(MAX_RESULTS))
    `RSLUS_ASSERT(a_cnt_bound, r_cnt <= CCNT_W'(CHUNKS))
    `RSLUS_ASSERT_IMP(a_idle_no_hold, r_state == S_IDLE, !r_hold_vld)

endmodule
